>>> rtl/abblit_pkg.sv
package abblit_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // source sizes saturate here
    localparam logic [10:0] SRC_LIMIT = 11'd1024;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CANVAS_ALPHA  = 2'd2;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    // canvas word layout, red in the low byte
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } pixel_t;

    // input word layout, first field in the low bits
    typedef struct packed {
        logic        pad;
        logic [7:0]  alpha;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        src_has_alpha;
        logic [10:0] src_height;
        logic [10:0] src_width;
        logic [7:0]  pos_y;
        logic [7:0]  pos_x;
    } in_word_t;

    function automatic int max_int(int a, int b);
        return (a > b) ? a : b;
    endfunction

    // exact floor(x / 255) for x up to 255 * 255
    function automatic logic [7:0] div255(logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'd1 + 17'(x[15:8]);
        return t[15:8];
    endfunction

endpackage

>>> rtl/alpha_blend_blitter_top.sv
// sequence: begin, dropped pixel, off-canvas read and unused command go from accept
//   to finish; a canvas hit (pixel or read) passes read, multiply and divide first
// flow: one word at a time; the single read-modify-write sequencer on the canvas
//   memory (read, multiply, divide, write back) takes no word until it is idle again
// reset: rst_n clears control and config at once, then a clearing pass zeroes the
//   canvas, every one of its MAX_WIDTH * MAX_HEIGHT words, with s_axis_tready low
module alpha_blend_blitter_top
    import abblit_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)(
    input  logic        clk,
    input  logic        rst_n,

    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x, pos_y, src_width, src_height, src_has_alpha, red, green, blue, alpha, pad
    input  logic [71:0] s_axis_tdata,
    // command
    input  logic [1:0]  s_axis_tuser,

    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0] m_axis_tdata,
    // written
    output logic        m_axis_tuser,
    // paste_done
    output logic        m_axis_tlast,

    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = max_int(1, $clog2(DEPTH));
    localparam int COL_W  = max_int(1, $clog2(MAX_WIDTH));
    localparam int ROW_W  = max_int(1, $clog2(MAX_HEIGHT));
    localparam int DIM_W  = max_int(11, max_int($clog2(MAX_WIDTH + 1),
                                                $clog2(MAX_HEIGHT + 1)));

    // canvas store, one 32-bit word per pixel
    logic [31:0] canvas_mem [DEPTH];

    // control state
    state_t      state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [8:0]  canvas_width_reg, canvas_height_reg;
    logic        canvas_alpha_reg;

    // paste context
    logic [7:0]  origin_col_reg, origin_col_next;
    logic [7:0]  origin_row_reg, origin_row_next;
    logic [10:0] source_cols_reg, source_cols_next;
    logic [10:0] source_rows_reg, source_rows_next;
    logic        src_alpha_reg, src_alpha_next;
    logic [9:0]  cursor_col_reg, cursor_col_next;
    logic [9:0]  cursor_row_reg, cursor_row_next;
    logic        paste_active_reg, paste_active_next;

    // item in flight
    logic             hit_reg;
    logic             is_read_reg;
    logic             written_reg;
    logic             done_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [7:0]       red_reg, green_reg, blue_reg, alpha_reg;
    logic [31:0]      rd_data_reg;
    logic [15:0]      prod_r_reg, prod_g_reg, prod_b_reg, prod_a_reg;
    pixel_t           new_word_reg;

    // output slot
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_user_reg;
    logic        out_last_reg;

    in_word_t    in_word;
    cmd_t        in_cmd;
    logic        in_fire;
    logic        out_free;
    logic [DIM_W-1:0] eff_width, eff_height;
    logic [10:0] pix_col, pix_row, sel_col, sel_row;
    logic        sel_hit;
    logic        sel_mem;
    logic        sel_written;
    logic        col_wrap, row_wrap;
    logic [ADDR_W-1:0] pix_addr;
    logic        rd_en;
    logic        wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0] wr_data;
    pixel_t      old_pix;
    logic [7:0]  sa;
    logic [7:0]  inv_sa;
    pixel_t      fin_out;

    assign in_word  = in_word_t'(s_axis_tdata);
    assign in_cmd   = cmd_t'(s_axis_tuser);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    // effective canvas size, clamped to the store
    assign eff_width  = (DIM_W'(canvas_width_reg) < DIM_W'(MAX_WIDTH)) ?
                        DIM_W'(canvas_width_reg) : DIM_W'(MAX_WIDTH);
    assign eff_height = (DIM_W'(canvas_height_reg) < DIM_W'(MAX_HEIGHT)) ?
                        DIM_W'(canvas_height_reg) : DIM_W'(MAX_HEIGHT);

    // target position: cursor over origin for a pixel, given position for a read
    assign pix_col = 11'(origin_col_reg) + 11'(cursor_col_reg);
    assign pix_row = 11'(origin_row_reg) + 11'(cursor_row_reg);
    assign sel_col = (in_cmd == CMD_READ) ? 11'(in_word.pos_x) : pix_col;
    assign sel_row = (in_cmd == CMD_READ) ? 11'(in_word.pos_y) : pix_row;
    assign sel_hit = (DIM_W'(sel_col) < eff_width) && (DIM_W'(sel_row) < eff_height);

    assign sel_written = (in_cmd == CMD_PIXEL) && paste_active_reg && sel_hit;
    assign sel_mem     = sel_written || ((in_cmd == CMD_READ) && sel_hit);

    assign col_wrap = (11'(cursor_col_reg) + 11'd1) >= source_cols_reg;
    assign row_wrap = (11'(cursor_row_reg) + 11'd1) >= source_rows_reg;

    // row-major word address
    assign pix_addr = ADDR_W'(row_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_reg);

    // sequencer and paste context
    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        origin_col_next   = origin_col_reg;
        origin_row_next   = origin_row_reg;
        source_cols_next  = source_cols_reg;
        source_rows_next  = source_rows_reg;
        src_alpha_next    = src_alpha_reg;
        cursor_col_next   = cursor_col_reg;
        cursor_row_next   = cursor_row_reg;
        paste_active_next = paste_active_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = sel_mem ? ST_READ : ST_FIN;
                    case (in_cmd)
                        CMD_BEGIN:
                        begin
                            origin_col_next  = in_word.pos_x;
                            origin_row_next  = in_word.pos_y;
                            source_cols_next = (in_word.src_width > SRC_LIMIT) ?
                                               SRC_LIMIT : in_word.src_width;
                            source_rows_next = (in_word.src_height > SRC_LIMIT) ?
                                               SRC_LIMIT : in_word.src_height;
                            src_alpha_next   = in_word.src_has_alpha;
                            cursor_col_next  = '0;
                            cursor_row_next  = '0;
                            paste_active_next = (source_cols_next != '0) &&
                                                (source_rows_next != '0);
                        end
                        CMD_PIXEL:
                        begin
                            if (paste_active_reg)
                            begin
                                if (col_wrap)
                                begin
                                    cursor_col_next = '0;
                                    if (row_wrap)
                                    begin
                                        cursor_row_next   = '0;
                                        paste_active_next = 1'b0;
                                    end
                                    else
                                    begin
                                        cursor_row_next = cursor_row_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    cursor_col_next = cursor_col_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            origin_col_reg    <= '0;
            origin_row_reg    <= '0;
            source_cols_reg   <= '0;
            source_rows_reg   <= '0;
            src_alpha_reg     <= 1'b0;
            cursor_col_reg    <= '0;
            cursor_row_reg    <= '0;
            paste_active_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_cnt_reg       <= clr_cnt_next;
            origin_col_reg    <= origin_col_next;
            origin_row_reg    <= origin_row_next;
            source_cols_reg   <= source_cols_next;
            source_rows_reg   <= source_rows_next;
            src_alpha_reg     <= src_alpha_next;
            cursor_col_reg    <= cursor_col_next;
            cursor_row_reg    <= cursor_row_next;
            paste_active_reg  <= paste_active_next;
        end
    end

    // configuration registers, writes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= 9'd256;
            canvas_height_reg <= 9'd256;
            canvas_alpha_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data;
                REG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data;
                REG_CANVAS_ALPHA:  canvas_alpha_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // item capture at accept
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hit_reg     <= sel_mem;
            is_read_reg <= (in_cmd == CMD_READ);
            written_reg <= sel_written;
            done_reg    <= (in_cmd == CMD_PIXEL) && paste_active_reg && col_wrap && row_wrap;
            col_reg     <= COL_W'(sel_col);
            row_reg     <= ROW_W'(sel_row);
            red_reg     <= in_word.red;
            green_reg   <= in_word.green;
            blue_reg    <= in_word.blue;
            alpha_reg   <= in_word.alpha;
        end
    end

    // canvas memory with a registered read port
    assign rd_en   = (state_reg == ST_READ);
    assign wr_en   = (state_reg == ST_CLEAR) || ((state_reg == ST_FIN) && out_free && hit_reg);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : pix_addr;
    assign wr_data = ((state_reg == ST_CLEAR) || is_read_reg) ? 32'd0 : 32'(new_word_reg);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= canvas_mem[pix_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            canvas_mem[wr_addr] <= wr_data;
        end
    end

    // blend arithmetic
    assign old_pix = pixel_t'(rd_data_reg);
    assign sa      = src_alpha_reg ? alpha_reg : 8'd255;
    assign inv_sa  = 8'd255 - sa;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_r_reg <= 16'(old_pix.r) * 16'(inv_sa) + 16'(red_reg) * 16'(sa);
            prod_g_reg <= 16'(old_pix.g) * 16'(inv_sa) + 16'(green_reg) * 16'(sa);
            prod_b_reg <= 16'(old_pix.b) * 16'(inv_sa) + 16'(blue_reg) * 16'(sa);
            prod_a_reg <= 16'(old_pix.a) * 16'(inv_sa) + 16'(8'd255) * 16'(sa);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV)
        begin
            if (!canvas_alpha_reg)
            begin
                // rgb canvas keeps the stored alpha byte
                new_word_reg <= '{a: old_pix.a, b: blue_reg, g: green_reg, r: red_reg};
            end
            else if (old_pix.a != 8'd0)
            begin
                new_word_reg <= '{a: div255(prod_a_reg), b: div255(prod_b_reg),
                                  g: div255(prod_g_reg), r: div255(prod_r_reg)};
            end
            else
            begin
                // empty destination is overwritten
                new_word_reg <= '{a: sa, b: blue_reg, g: green_reg, r: red_reg};
            end
        end
    end

    // result of a read hit, alpha masked on an rgb canvas
    always_comb
    begin
        fin_out = '0;
        if (hit_reg && is_read_reg)
        begin
            fin_out   = old_pix;
            fin_out.a = canvas_alpha_reg ? old_pix.a : 8'd0;
        end
    end

    // output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FIN) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FIN) && out_free)
        begin
            out_data_reg <= 32'(fin_out);
            out_user_reg <= written_reg;
            out_last_reg <= done_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // no word is taken while the canvas is being cleared
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during canvas clear");

    // outside the clearing pass the canvas is written only on a hit
    a_write_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (state_reg != ST_CLEAR)) |-> hit_reg)
        else $error("canvas written without a hit");

    // a landed pixel reports no color
    a_pixel_no_color: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0))
        else $error("pixel result carries color data");

    // a finished item waits while the output slot is full
    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && !out_free) |=> (state_reg == ST_FIN))
        else $error("result dropped while output slot full");

endmodule
